>>> rtl/tlb_clock_replacement_top_macros.svh
// assertion helpers for the tlb rtl
// the asserting module must have clk and rst_n in scope
`ifndef TLB_CLOCK_REPLACEMENT_TOP_MACROS_SVH
`define TLB_CLOCK_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication
`define TLBCLK_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLBCLK_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tlbclk_pkg.sv
`timescale 1ns / 1ps

package tlbclk_pkg;

    // fixed field widths of the request and response channels
    localparam int IN_VPN_W   = 20;
    localparam int IN_PFN_W   = 20;
    localparam int OUT_PFN_W  = 20;
    localparam int OUT_SLOT_W = 4;

    // tag compare lanes per search step
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FETCH  = 3'b100
    } tlbclk_state_t;

    // request queue status
    typedef struct packed {
        logic empty;
        logic full;
    } tlbclk_qstat_t;

endpackage

>>> rtl/tlbclk_in_if.sv
`timescale 1ns / 1ps

interface tlbclk_in_if;
    import tlbclk_pkg::*;

    logic                valid;
    logic                ready;
    logic [IN_VPN_W-1:0] vpn;
    logic                is_write;
    logic [IN_PFN_W-1:0] walk_pfn;

    modport source (output valid, vpn, is_write, walk_pfn, input ready);
    modport sink   (input valid, vpn, is_write, walk_pfn, output ready);
endinterface

>>> rtl/tlbclk_out_if.sv
`timescale 1ns / 1ps

interface tlbclk_out_if;
    import tlbclk_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [OUT_PFN_W-1:0]  pfn;
    logic [OUT_SLOT_W-1:0] slot;

    modport source (output valid, hit, pfn, slot, input ready);
    modport sink   (input valid, hit, pfn, slot, output ready);
endinterface

>>> rtl/tlbclk_ram.sv
`timescale 1ns / 1ps

module tlbclk_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/tlbclk_fifo.sv
`timescale 1ns / 1ps

module tlbclk_fifo #(
    parameter int WIDTH = 41
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [WIDTH-1:0]            push_data,
    input  logic                        pop,
    output logic [WIDTH-1:0]            pop_data,
    output tlbclk_pkg::tlbclk_qstat_t   qstat
);
    import tlbclk_pkg::*;

    logic [WIDTH-1:0]  slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    // status and head
    always_comb
    begin
        qstat.empty = (count_reg == '0);
        qstat.full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
        pop_data    = slots_reg[rd_ptr_reg];
    end

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/tlbclk_front.sv
`timescale 1ns / 1ps

module tlbclk_front #(
    parameter int VPN_BITS = 20,
    parameter int PFN_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tlbclk_in_if.sink                       req,
    input  tlbclk_pkg::tlbclk_qstat_t       qstat,
    output logic                            push,
    output logic [VPN_BITS+PFN_BITS:0]      push_data
);
    import tlbclk_pkg::*;

    logic                         stage_valid_reg, stage_valid_next;
    logic [VPN_BITS-1:0]          page_reg;
    logic                         wr_reg;
    logic [PFN_BITS-1:0]          frame_reg;
    logic                         accept;
    logic [VPN_BITS+IN_VPN_W-1:0] page_wide;
    logic [PFN_BITS+IN_PFN_W-1:0] frame_wide;

    // stage handshake: refill while the held request moves to the queue
    always_comb
    begin
        req.ready        = !stage_valid_reg || !qstat.full;
        push             = stage_valid_reg && !qstat.full;
        accept           = req.valid && req.ready;
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // fit page and frame to the stored widths
    always_comb
    begin
        page_wide  = {{VPN_BITS{1'b0}}, req.vpn};
        frame_wide = {{PFN_BITS{1'b0}}, req.walk_pfn};
        push_data  = {page_reg, wr_reg, frame_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg  <= page_wide[VPN_BITS-1:0];
            wr_reg    <= req.is_write;
            frame_reg <= frame_wide[PFN_BITS-1:0];
        end
    end

endmodule

>>> rtl/tlbclk_back.sv
`timescale 1ns / 1ps
`include "tlb_clock_replacement_top_macros.svh"

module tlbclk_back #(
    parameter int ENTRIES  = 16,
    parameter int VPN_BITS = 20,
    parameter int PFN_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlbclk_pkg::tlbclk_qstat_t       qstat,
    input  logic [VPN_BITS+PFN_BITS:0]      q_data,
    output logic                            q_pop,
    tlbclk_out_if.source                    rsp
);
    import tlbclk_pkg::*;

    localparam int NCHUNK  = (ENTRIES + LANES - 1) / LANES;
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W   = CHUNK_W + LANE_W;
    localparam int SLOTS   = 1 << PAD_W;

    tlbclk_state_t        state_reg, state_next;
    logic [VPN_BITS-1:0]  page_reg;
    logic                 wr_reg;
    logic [PFN_BITS-1:0]  walk_reg;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic [PAD_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [SLOTS-1:0]     used_reg, used_next;
    logic [SLOTS-1:0]     dirty_reg, dirty_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg;
    logic [OUT_PFN_W-1:0] out_pfn_reg;
    logic [OUT_SLOT_W-1:0] out_slot_reg;

    logic [VPN_BITS-1:0]  page_rd [LANES];
    logic [LANES-1:0]     lane_match;
    logic                 any_match;
    logic [LANE_W-1:0]    match_lane;
    logic [PAD_W-1:0]     hit_idx;
    logic                 last_chunk;
    logic [CHUNK_W-1:0]   rd_chunk;
    logic [PFN_BITS-1:0]  frame_rd_data;

    logic                 inv_found;
    logic [PAD_W-1:0]     inv_idx;
    logic                 clr_found;
    logic [PAD_W-1:0]     clr_idx;
    logic [SLOTS-1:0]     sweep_clear;
    logic [PAD_W-1:0]     victim_idx;

    logic                 start;
    logic                 install;
    logic                 res_load;
    logic                 res_hit;
    logic [PFN_BITS-1:0]  res_frame;
    logic [PAD_W-1:0]     res_idx;
    logic [PFN_BITS+OUT_PFN_W-1:0]  res_frame_wide;
    logic [PAD_W+OUT_SLOT_W-1:0]    res_idx_wide;

    // page store: one ram per lane, one chunk row read per cycle
    assign rd_chunk = (state_reg == ST_SEARCH) ? chunk_reg + CHUNK_W'(1) : '0;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        tlbclk_ram #(
            .WIDTH (VPN_BITS),
            .DEPTH (1 << CHUNK_W)
        ) u_page_ram (
            .clk   (clk),
            .we    (install && (victim_idx[LANE_W-1:0] == LANE_W'(l))),
            .waddr (victim_idx[PAD_W-1:LANE_W]),
            .wdata (page_reg),
            .raddr (rd_chunk),
            .rdata (page_rd[l])
        );
    end

    // frame store, read at the hit entry
    tlbclk_ram #(
        .WIDTH (PFN_BITS),
        .DEPTH (SLOTS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (install),
        .waddr (victim_idx),
        .wdata (walk_reg),
        .raddr (hit_idx),
        .rdata (frame_rd_data)
    );

    // tag compare over the current chunk, lowest lane wins
    always_comb
    begin
        any_match  = 1'b0;
        match_lane = '0;
        for (int l = 0; l < LANES; l++)
        begin
            lane_match[l] = valid_reg[{chunk_reg, LANE_W'(l)}] && (page_rd[l] == page_reg);
        end
        for (int l = 0; l < LANES; l++)
        begin
            if (lane_match[l] && !any_match)
            begin
                any_match  = 1'b1;
                match_lane = LANE_W'(l);
            end
        end
        hit_idx    = {chunk_reg, match_lane};
        last_chunk = (chunk_reg == CHUNK_W'(NCHUNK - 1));
    end

    // victim: first invalid entry, else clock sweep from entry 0
    always_comb
    begin
        inv_found   = 1'b0;
        inv_idx     = '0;
        clr_found   = 1'b0;
        clr_idx     = '0;
        sweep_clear = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (!valid_reg[k] && !inv_found)
            begin
                inv_found = 1'b1;
                inv_idx   = PAD_W'(k);
            end
            if (!clr_found)
            begin
                if (!used_reg[k])
                begin
                    clr_found = 1'b1;
                    clr_idx   = PAD_W'(k);
                end
                else
                begin
                    sweep_clear[k] = 1'b1;
                end
            end
        end
        victim_idx = inv_found ? inv_idx : clr_idx;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        chunk_next   = chunk_reg;
        hit_idx_next = hit_idx_reg;
        valid_next   = valid_reg;
        used_next    = used_reg;
        dirty_next   = dirty_reg;
        start        = 1'b0;
        install      = 1'b0;
        res_load     = 1'b0;
        res_hit      = 1'b0;
        res_frame    = walk_reg;
        res_idx      = victim_idx;
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty && (!out_valid_reg || rsp.ready))
                begin
                    start      = 1'b1;
                    chunk_next = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (any_match)
                begin
                    hit_idx_next        = hit_idx;
                    used_next[hit_idx]  = 1'b1;
                    dirty_next[hit_idx] = wr_reg;
                    state_next          = ST_FETCH;
                end
                else if (last_chunk)
                begin
                    install  = 1'b1;
                    res_load = 1'b1;
                    if (!inv_found)
                    begin
                        used_next = used_reg & ~sweep_clear;
                    end
                    valid_next[victim_idx] = 1'b1;
                    used_next[victim_idx]  = 1'b1;
                    dirty_next[victim_idx] = wr_reg;
                    state_next             = ST_IDLE;
                end
                else
                begin
                    chunk_next = chunk_reg + CHUNK_W'(1);
                end
            end
            ST_FETCH:
            begin
                res_load   = 1'b1;
                res_hit    = 1'b1;
                res_frame  = frame_rd_data;
                res_idx    = hit_idx_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        q_pop = start;
    end

    // result formatting and output register
    always_comb
    begin
        res_frame_wide = {{OUT_PFN_W{1'b0}}, res_frame};
        res_idx_wide   = {{OUT_SLOT_W{1'b0}}, res_idx};
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.hit   = out_hit_reg;
    assign rsp.pfn   = out_pfn_reg;
    assign rsp.slot  = out_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chunk_reg     <= '0;
            hit_idx_reg   <= '0;
            valid_reg     <= '0;
            used_reg      <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            hit_idx_reg   <= hit_idx_next;
            valid_reg     <= valid_next;
            used_reg      <= used_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request under work and response payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            page_reg <= q_data[VPN_BITS+PFN_BITS:PFN_BITS+1];
            wr_reg   <= q_data[PFN_BITS];
            walk_reg <= q_data[PFN_BITS-1:0];
        end
        if (res_load)
        begin
            out_hit_reg  <= res_hit;
            out_pfn_reg  <= res_frame_wide[OUT_PFN_W-1:0];
            out_slot_reg <= res_idx_wide[OUT_SLOT_W-1:0];
        end
    end

    // checks
    `TLBCLK_CHECK_NOW(a_result_slot_free, res_load, !out_valid_reg || rsp.ready, "response register overwritten")
    `TLBCLK_CHECK_NEXT(a_install_marks, install, valid_reg[$past(victim_idx)] && used_reg[$past(victim_idx)], "installed entry not valid and used")
    `TLBCLK_CHECK_NEXT(a_valid_sticky, 1'b1, (valid_reg & $past(valid_reg)) == $past(valid_reg), "valid bit dropped")
    `TLBCLK_CHECK_NEXT(a_fetch_returns, state_reg == ST_FETCH, state_reg == ST_IDLE && out_valid_reg, "hit fetch did not respond")

endmodule

>>> rtl/tlb_clock_replacement_top.sv
`timescale 1ns / 1ps

// Fully associative TLB with clock replacement. A request passes a front
// stage and a two-deep queue, then a back-end sequencer searches the tags
// eight entries per cycle out of per-lane page rams and either returns the
// stored frame (hit) or installs the walk frame in the first invalid entry or
// the clock-sweep victim (miss). One request is in the back end at a time:
// the search walks chunks of eight entries from chunk 0 and stops at the
// first chunk with a match, then a hit reads the frame ram in the fetch
// state before it responds; a miss searches every chunk and installs and
// responds at the last one. Page and frame storage need no clearing pass
// after reset; the valid, used and dirty flops clear.
module tlb_clock_replacement_top #(
    parameter int ENTRIES  = 16,
    parameter int VPN_BITS = 20,
    parameter int PFN_BITS = 20
) (
    input  logic           clk,
    input  logic           rst_n,
    tlbclk_in_if.sink      req,
    tlbclk_out_if.source   rsp
);
    import tlbclk_pkg::*;

    localparam int QW = VPN_BITS + PFN_BITS + 1;

    tlbclk_qstat_t   qstat;
    logic            push;
    logic [QW-1:0]   push_data;
    logic            pop;
    logic [QW-1:0]   pop_data;

    // request intake
    tlbclk_front #(
        .VPN_BITS (VPN_BITS),
        .PFN_BITS (PFN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    tlbclk_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    // lookup and replacement
    tlbclk_back #(
        .ENTRIES  (ENTRIES),
        .VPN_BITS (VPN_BITS),
        .PFN_BITS (PFN_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .q_data (pop_data),
        .q_pop  (pop),
        .rsp    (rsp)
    );

endmodule

>>> tb/tlb_clock_replacement_top_tb.sv
`timescale 1ns / 1ps

module tlb_clock_replacement_top_tb;
    import tlbclk_pkg::*;

    localparam int TLB_ENTRIES = 16;
    localparam int RANDOM_REQS = 1650;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic [IN_VPN_W-1:0] vpn;
        logic                is_write;
        logic [IN_PFN_W-1:0] walk_pfn;
    } xlate_req_t;

    typedef struct packed {
        logic                  hit;
        logic [OUT_PFN_W-1:0]  pfn;
        logic [OUT_SLOT_W-1:0] slot;
    } xlate_rsp_t;

    logic clk;
    logic rst_n;

    tlbclk_in_if  req_if ();
    tlbclk_out_if rsp_if ();

    tlb_clock_replacement_top #(
        .ENTRIES  (TLB_ENTRIES),
        .VPN_BITS (IN_VPN_W),
        .PFN_BITS (IN_PFN_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the translation entries
    bit                  tag_valid [TLB_ENTRIES];
    bit                  tag_used  [TLB_ENTRIES];
    bit                  tag_dirty [TLB_ENTRIES];
    logic [IN_VPN_W-1:0] tag_page  [TLB_ENTRIES];
    logic [IN_PFN_W-1:0] tag_frame [TLB_ENTRIES];

    xlate_req_t pending_reqs [$];
    xlate_rsp_t expected_xlate [$];
    xlate_req_t cur_req;

    int total_reqs;
    int sent_reqs;
    int error_count;
    int hit_count;
    int miss_count;
    int sweep_count;
    int req_idle_left;
    int rsp_stall_left;
    bit req_burst;
    bit rsp_burst;

    // lookup, then fill on a miss: first invalid entry, else clock sweep from entry 0
    function automatic void predict_translation(xlate_req_t r);
        int k;
        int found;
        xlate_rsp_t e;
        found = -1;
        for (k = 0; k < TLB_ENTRIES; k++)
        begin
            if (found < 0 && tag_valid[k] && tag_page[k] == r.vpn)
                found = k;
        end
        if (found >= 0)
        begin
            tag_used[found]  = 1'b1;
            tag_dirty[found] = r.is_write;
            e.hit  = 1'b1;
            e.pfn  = tag_frame[found];
            e.slot = 4'(found);
            hit_count++;
        end
        else
        begin
            for (k = 0; k < TLB_ENTRIES; k++)
            begin
                if (found < 0 && !tag_valid[k])
                    found = k;
            end
            if (found < 0)
            begin
                sweep_count++;
                for (k = 0; k < TLB_ENTRIES; k++)
                begin
                    if (found < 0)
                    begin
                        if (!tag_used[k])
                            found = k;
                        else
                            tag_used[k] = 1'b0;
                    end
                end
                // every used bit was set: wrap to entry 0
                if (found < 0)
                    found = 0;
            end
            tag_page[found]  = r.vpn;
            tag_frame[found] = r.walk_pfn;
            tag_valid[found] = 1'b1;
            tag_used[found]  = 1'b1;
            tag_dirty[found] = r.is_write;
            e.hit  = 1'b0;
            e.pfn  = r.walk_pfn;
            e.slot = 4'(found);
            miss_count++;
        end
        expected_xlate.push_back(e);
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver with random idle gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                predict_translation(cur_req);
                sent_reqs++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (req_idle_left > 0)
                begin
                    req_idle_left--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    req_if.vpn      <= cur_req.vpn;
                    req_if.is_write <= cur_req.is_write;
                    req_if.walk_pfn <= cur_req.walk_pfn;
                    req_if.valid    <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        req_burst = ~req_burst;
                    req_idle_left = req_burst ? 0 : $urandom_range(0, 9);
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_xlate.size() == 0)
                begin
                    $error("unexpected response: hit %0d pfn 0x%05h slot %0d",
                           rsp_if.hit, rsp_if.pfn, rsp_if.slot);
                    error_count++;
                end
                else
                begin
                    xlate_rsp_t e;
                    e = expected_xlate.pop_front();
                    if (rsp_if.hit !== e.hit)
                    begin
                        $error("hit mismatch: expected %0d, actual %0d", e.hit, rsp_if.hit);
                        error_count++;
                    end
                    if (rsp_if.pfn !== e.pfn)
                    begin
                        $error("pfn mismatch: expected 0x%05h, actual 0x%05h",
                               e.pfn, rsp_if.pfn);
                        error_count++;
                    end
                    if (rsp_if.slot !== e.slot)
                    begin
                        $error("slot mismatch: expected %0d, actual %0d", e.slot, rsp_if.slot);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rsp_burst = ~rsp_burst;
                rsp_stall_left = rsp_burst ? 0 : $urandom_range(0, 9);
            end
            if (rsp_stall_left > 0)
            begin
                rsp_stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [IN_VPN_W-1:0] page_pool [POOL_SIZE];
        xlate_req_t r;
        int i;
        int pool_span;

        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.vpn      = '0;
        req_if.is_write = 1'b0;
        req_if.walk_pfn = '0;
        rsp_if.ready    = 1'b0;
        sent_reqs       = 0;
        error_count     = 0;
        hit_count       = 0;
        miss_count      = 0;
        sweep_count     = 0;
        req_idle_left   = 0;
        rsp_stall_left  = 0;
        req_burst       = 1'b0;
        rsp_burst       = 1'b0;
        for (i = 0; i < TLB_ENTRIES; i++)
        begin
            tag_valid[i] = 1'b0;
            tag_used[i]  = 1'b0;
            tag_dirty[i] = 1'b0;
        end

        // directed: field extremes, hits on both, then fill every entry
        pending_reqs.push_back('{vpn: 20'h00000, is_write: 1'b0, walk_pfn: 20'h00000});
        pending_reqs.push_back('{vpn: 20'hFFFFF, is_write: 1'b1, walk_pfn: 20'hFFFFF});
        pending_reqs.push_back('{vpn: 20'h00000, is_write: 1'b1, walk_pfn: 20'hFFFFF});
        pending_reqs.push_back('{vpn: 20'hFFFFF, is_write: 1'b0, walk_pfn: 20'h00000});
        for (i = 2; i < TLB_ENTRIES; i++)
        begin
            r.vpn      = {4'(i), 16'hA5C3};
            r.is_write = 1'(i);
            r.walk_pfn = 20'($urandom);
            pending_reqs.push_back(r);
        end
        // all entries valid and used: sweep clears everything and takes entry 0
        pending_reqs.push_back('{vpn: 20'h12345, is_write: 1'b0, walk_pfn: 20'h5A5A5});
        // touch entry 3, then a miss skips entry 0 and lands on entry 1
        pending_reqs.push_back('{vpn: {4'd3, 16'hA5C3}, is_write: 1'b0, walk_pfn: 20'h0});
        pending_reqs.push_back('{vpn: 20'h54321, is_write: 1'b1, walk_pfn: 20'hA5A5A});
        pending_reqs.push_back('{vpn: 20'h12345, is_write: 1'b1, walk_pfn: 20'h0});
        pending_reqs.push_back('{vpn: 20'h00000, is_write: 1'b0, walk_pfn: 20'h13579});

        // random: mostly a shifting hot set of pages, some fully random pages
        for (i = 0; i < POOL_SIZE; i++)
            page_pool[i] = 20'($urandom);
        pool_span = POOL_SIZE;
        for (i = 0; i < RANDOM_REQS; i++)
        begin
            if (i % 100 == 0)
                pool_span = $urandom_range(4, POOL_SIZE);
            if (i % 50 == 0)
                page_pool[$urandom_range(0, POOL_SIZE - 1)] = 20'($urandom);
            if ($urandom_range(0, 99) < 85)
                r.vpn = page_pool[$urandom_range(0, pool_span - 1)];
            else
                r.vpn = 20'($urandom);
            r.is_write = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 19))
                0:       r.walk_pfn = 20'h00000;
                1:       r.walk_pfn = 20'hFFFFF;
                default: r.walk_pfn = 20'($urandom);
            endcase
            pending_reqs.push_back(r);
        end
        total_reqs = pending_reqs.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (sent_reqs < total_reqs)
            @(posedge clk);
        while (expected_xlate.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("translated %0d requests: %0d hits, %0d misses, %0d clock sweeps",
                 sent_reqs, hit_count, miss_count, sweep_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d responses outstanding", expected_xlate.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/tlbclk_pkg.sv
rtl/tlbclk_in_if.sv
rtl/tlbclk_out_if.sv
rtl/tlbclk_ram.sv
rtl/tlbclk_fifo.sv
rtl/tlbclk_front.sv
rtl/tlbclk_back.sv
rtl/tlb_clock_replacement_top.sv
tb/tlb_clock_replacement_top_tb.sv
